// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FRA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fra check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FRA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fra check failed");

`endif

// ===== rtl/core/fra_pkg.sv =====
// Package of the fragment reassembly tracker: codes, record type, fixed constants.
package fra_pkg;

	// Input kinds.
	localparam logic [1:0] KIND_FRAG = 2'd0;
	localparam logic [1:0] KIND_PKT  = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_INCOMPLETE = 2'd0;
	localparam logic [1:0] STAT_COMPLETE   = 2'd1;
	localparam logic [1:0] STAT_DROPPED    = 2'd2;
	localparam logic [1:0] STAT_NONE       = 2'd3;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRUNE_INT = 4'd1;

	// Register reset values.
	localparam logic [15:0] MAX_AGE_RESET   = 16'd30;
	localparam logic [15:0] PRUNE_INT_RESET = 16'd100;

	// Fragment lengths above this are clamped.
	localparam logic [15:0] MAX_FRAG_BYTES = 16'd2048;

	localparam logic [23:0] BYTES_MAX = 24'hFFFFFF;

	// One reassembly context as stored in the table memory.
	typedef struct packed {
		logic [63:0] host;
		logic [63:0] msg;
		logic [23:0] bytes;
		logic [31:0] birth;
	} rec_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_FINISH
	} fsm_t;

endpackage

// ===== rtl/core/fra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fra_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/fragment_reassembly_tracker_unit.sv =====
// Top level of the fragment reassembly tracker: table scan, update and prune.
//
// Input channel (in_valid/in_stall): one word per item, kind plus fragment fields.
// Output channel (out_valid/out_stall): exactly one result word per input word.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; index 0 sets
// max_age_seconds, index 1 sets prune_interval, other indexes are ignored.
//
// The contexts live in one RAM of ENTRIES records. A fragment walks the whole
// RAM, one read a cycle, to find the host, the lowest free entry and the aged
// entries, then writes back one record from the finish state. Other kinds go
// from idle straight to the finish state. Every result is registered in the
// finish state, and the next item is taken only after the return to idle.
// Valid bits sit in flip-flops; the RAM needs no clearing after reset.
//
// Reset empties the table, zeroes the seconds counter and prune phase and loads
// the register defaults. A result waits in the output register while out_stall
// is high; the next item is accepted and worked on meanwhile and holds in its
// final step until the output register is free.
module fragment_reassembly_tracker_unit #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [63:0]                    host_id,
	input  logic [63:0]                    msg_id,
	input  logic [23:0]                    msg_size,
	input  logic [11:0]                    frag_len,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic                           restarted,
	output logic [63:0]                    done_host_id,
	output logic [63:0]                    done_msg_id,
	output logic [4:0]                     evicted,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]                    cfg_data
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
	localparam int unsigned REC_W = $bits(fra_pkg::rec_t);

	fra_pkg::fsm_t state_q, state_d;

	// accepted item
	logic [1:0]  kind_q;
	logic [63:0] host_q;
	logic [63:0] msg_q;
	logic [23:0] size_q;
	logic [11:0] flen_q;

	// block state
	logic [ENTRIES-1:0] valid_q;
	logic [31:0]        seconds_q;
	logic [15:0]        phase_q;
	logic [15:0]        max_age_q;
	logic [15:0]        prune_int_q;

	// scan state
	logic [CNT_W-1:0]   scan_q;
	logic               chk_vld_s1;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	fra_pkg::rec_t      hit_rec_q;
	logic               free_found_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [ENTRIES-1:0] aged_q;
	logic [CNT_W-1:0]   aged_cnt_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        restarted_q;
	logic [63:0] done_host_q;
	logic [63:0] done_msg_q;
	logic [4:0]  evicted_q;

	// control
	logic accept;
	logic rd_en;
	logic commit;
	logic out_free;

	// RAM
	logic [REC_W-1:0] rd_data;
	fra_pkg::rec_t    rd_rec;
	fra_pkg::rec_t    wr_rec;
	logic             wr_en;
	logic [IDX_W-1:0] rd_addr;

	// finish datapath
	logic               restart;
	logic               alloc;
	logic               drop;
	logic [IDX_W-1:0]   tgt;
	logic [23:0]        base_bytes;
	logic [15:0]        flen_clamp;
	logic [24:0]        byte_sum;
	logic [23:0]        bytes_sat;
	logic               complete;
	logic               prune_now;
	logic [ENTRIES-1:0] aged_adj;
	logic [ENTRIES-1:0] valid_frag;
	logic [CNT_W-1:0]   aged_cnt_adj;
	logic [CNT_W+4:0]   aged_cnt_ext;
	logic [4:0]         evict_sat;
	logic [15:0]        period;
	logic [16:0]        phase_inc;
	logic [15:0]        phase_next;

	// next result word
	logic [1:0]  res_status;
	logic        res_restarted;
	logic [63:0] res_done_host;
	logic [63:0] res_done_msg;
	logic [4:0]  res_evicted;

	// scan datapath
	logic        chk_entry_valid;
	logic        chk_match;
	logic        chk_aged;
	logic [31:0] chk_age;

	assign cfg_ready   = 1'b1;
	assign out_free    = !out_valid_q || !out_stall;
	assign rd_rec      = fra_pkg::rec_t'(rd_data);
	assign rd_addr     = scan_q[IDX_W-1:0];

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign restarted    = restarted_q;
	assign done_host_id = done_host_q;
	assign done_msg_id  = done_msg_q;
	assign evicted      = evicted_q;

	fra_ram #(
		.WIDTH (REC_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (tgt),
		.wdata (REC_W'(wr_rec)),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fra_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		rd_en    = 1'b0;
		commit   = 1'b0;
		unique case (state_q)
			fra_pkg::FSM_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = (kind == fra_pkg::KIND_FRAG) ? fra_pkg::FSM_SCAN
						: fra_pkg::FSM_FINISH;
				end
			end
			fra_pkg::FSM_SCAN: begin
				rd_en = (scan_q < CNT_W'(ENTRIES));
				if (chk_vld_s1 && chk_idx_s1 == IDX_W'(ENTRIES - 1)) begin
					state_d = fra_pkg::FSM_FINISH;
				end
			end
			fra_pkg::FSM_FINISH: begin
				commit = out_free;
				if (out_free) begin
					state_d = fra_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = fra_pkg::FSM_IDLE;
			end
		endcase
	end

	// per-entry checks on the word just read
	always_comb begin
		chk_entry_valid = valid_q[chk_idx_s1];
		chk_match       = chk_entry_valid && (rd_rec.host == host_q);
		chk_age         = seconds_q - rd_rec.birth;
		chk_aged        = chk_entry_valid && (chk_age > {16'd0, max_age_q});
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			chk_vld_s1   <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			aged_q       <= '0;
			aged_cnt_q   <= '0;
		end else if (accept) begin
			scan_q       <= '0;
			chk_vld_s1   <= 1'b0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
			aged_q       <= '0;
			aged_cnt_q   <= '0;
		end else begin
			chk_vld_s1 <= rd_en;
			if (rd_en) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (chk_vld_s1 && state_q == fra_pkg::FSM_SCAN) begin
				if (chk_match && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (!chk_entry_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				aged_q[chk_idx_s1] <= chk_aged;
				if (chk_aged) begin
					aged_cnt_q <= aged_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// scan payload and accepted item
	always_ff @(posedge clk) begin
		if (rd_en) begin
			chk_idx_s1 <= rd_addr;
		end
		if (chk_vld_s1 && state_q == fra_pkg::FSM_SCAN) begin
			if (chk_match && !hit_found_q) begin
				hit_idx_q <= chk_idx_s1;
				hit_rec_q <= rd_rec;
			end
			if (!chk_entry_valid && !free_found_q) begin
				free_idx_q <= chk_idx_s1;
			end
		end
		if (accept) begin
			kind_q <= kind;
			host_q <= host_id;
			msg_q  <= msg_id;
			size_q <= msg_size;
			flen_q <= frag_len;
		end
	end

	// fragment update and prune
	always_comb begin
		restart    = hit_found_q && (hit_rec_q.msg != msg_q);
		alloc      = !hit_found_q && free_found_q;
		drop       = !hit_found_q && !free_found_q;
		tgt        = hit_found_q ? hit_idx_q : free_idx_q;
		base_bytes = (restart || alloc) ? 24'd0 : hit_rec_q.bytes;
		flen_clamp = ({4'd0, flen_q} > fra_pkg::MAX_FRAG_BYTES) ? fra_pkg::MAX_FRAG_BYTES
			: {4'd0, flen_q};
		byte_sum   = {1'b0, base_bytes} + {9'd0, flen_clamp};
		bytes_sat  = byte_sum[24] ? fra_pkg::BYTES_MAX : byte_sum[23:0];
		complete   = !drop && (bytes_sat == size_q);

		wr_rec.host  = host_q;
		wr_rec.msg   = msg_q;
		wr_rec.bytes = bytes_sat;
		wr_rec.birth = (restart || alloc) ? seconds_q : hit_rec_q.birth;
		wr_en        = commit && (kind_q == fra_pkg::KIND_FRAG) && !drop;

		prune_now = (phase_q == 16'd0);
		for (int i = 0; i < ENTRIES; i++) begin
			// a restarted entry is reborn now and is not aged
			aged_adj[i]   = aged_q[i] && !(restart && tgt == IDX_W'(i));
			valid_frag[i] = (!drop && tgt == IDX_W'(i)) ? !complete : valid_q[i];
			if (prune_now && aged_adj[i]) begin
				valid_frag[i] = 1'b0;
			end
		end

		// drop one count when the aged hit entry was restarted or completed
		aged_cnt_adj = aged_cnt_q;
		if (hit_found_q && aged_q[hit_idx_q] && (restart || complete)) begin
			aged_cnt_adj = aged_cnt_q - CNT_W'(1);
		end
		aged_cnt_ext = (CNT_W + 5)'(aged_cnt_adj);
		evict_sat    = (aged_cnt_ext > (CNT_W + 5)'(31)) ? 5'd31 : aged_cnt_ext[4:0];

		period     = (prune_int_q == 16'd0) ? 16'd1 : prune_int_q;
		phase_inc  = {1'b0, phase_q} + 17'd1;
		phase_next = (phase_inc >= {1'b0, period}) ? 16'd0 : phase_inc[15:0];
	end

	// block state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			seconds_q   <= '0;
			phase_q     <= '0;
			max_age_q   <= fra_pkg::MAX_AGE_RESET;
			prune_int_q <= fra_pkg::PRUNE_INT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fra_pkg::CFG_MAX_AGE:   max_age_q   <= cfg_data;
					fra_pkg::CFG_PRUNE_INT: prune_int_q <= cfg_data;
					default: ;
				endcase
			end
			if (commit) begin
				case (kind_q)
					fra_pkg::KIND_FRAG: begin
						valid_q <= valid_frag;
						phase_q <= phase_next;
					end
					fra_pkg::KIND_PKT: begin
						phase_q <= phase_next;
					end
					fra_pkg::KIND_TICK: begin
						seconds_q <= seconds_q + 32'd1;
					end
					default: ;
				endcase
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word contents
	always_comb begin
		res_status    = fra_pkg::STAT_NONE;
		res_restarted = 1'b0;
		res_done_host = '0;
		res_done_msg  = '0;
		res_evicted   = '0;
		if (kind_q == fra_pkg::KIND_FRAG) begin
			res_restarted = restart;
			res_evicted   = prune_now ? evict_sat : 5'd0;
			if (drop) begin
				res_status = fra_pkg::STAT_DROPPED;
			end else if (complete) begin
				res_status    = fra_pkg::STAT_COMPLETE;
				res_done_host = host_q;
				res_done_msg  = msg_q;
			end else begin
				res_status = fra_pkg::STAT_INCOMPLETE;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= res_status;
			restarted_q <= res_restarted;
			done_host_q <= res_done_host;
			done_msg_q  <= res_done_msg;
			evicted_q   <= res_evicted;
		end
	end

endmodule

// ===== rtl/core/fra_checker.sv =====
// Port-level checker for the fragment reassembly tracker, bound to the top level.
`include "assert_macros.svh"

module fra_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        restarted,
	input logic [63:0] done_host_id,
	input logic [63:0] done_msg_id,
	input logic [4:0]  evicted
);

	// a stalled result word stays offered
	`FRA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

	// one item at a time: an accepted word keeps the input stalled next cycle
	`FRA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// non-fragment results carry no fragment information
	`FRA_ASSERT_NOW(a_none_clean, out_valid && status == fra_pkg::STAT_NONE,
		!restarted && done_host_id == 64'd0 && done_msg_id == 64'd0 && evicted == 5'd0)

	// ids are only reported on completion
	`FRA_ASSERT_NOW(a_ids_on_done, out_valid && status != fra_pkg::STAT_COMPLETE,
		done_host_id == 64'd0 && done_msg_id == 64'd0)

	// a dropped fragment never hit an entry, so it cannot restart one
	`FRA_ASSERT_NOW(a_drop_no_restart, out_valid && status == fra_pkg::STAT_DROPPED,
		!restarted)

endmodule

bind fragment_reassembly_tracker_unit fra_checker u_fra_checker (.*);

// ===== bench/tb_fragment_reassembly_tracker_unit.sv =====
// Self-checking bench for the fragment reassembly tracker: directed and random items.
module tb_fragment_reassembly_tracker_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ENTRIES = 16;
	localparam int POOL = 20;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam logic [fra_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'd7;

	typedef struct packed {
		logic [1:0]  status;
		logic        restarted;
		logic [63:0] host;
		logic [63:0] msg;
		logic [4:0]  evicted;
	} track_result_t;

	class reassembly_scoreboard;
		bit          slot_used[NUM_ENTRIES];
		bit [63:0]   slot_host[NUM_ENTRIES];
		bit [63:0]   slot_msg[NUM_ENTRIES];
		bit [23:0]   slot_bytes[NUM_ENTRIES];
		bit [31:0]   slot_birth[NUM_ENTRIES];
		bit [31:0]   seconds;
		bit [15:0]   phase;
		bit [15:0]   age_limit;
		bit [15:0]   period_reg;
		track_result_t due_results[$];
		int          errors;

		function new();
			for (int i = 0; i < NUM_ENTRIES; i++) slot_used[i] = 1'b0;
			seconds = '0;
			phase = '0;
			age_limit = fra_pkg::MAX_AGE_RESET;
			period_reg = fra_pkg::PRUNE_INT_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic [fra_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == fra_pkg::CFG_MAX_AGE) age_limit = val;
			else if (idx == fra_pkg::CFG_PRUNE_INT) period_reg = val;
		endfunction

		function void step_phase();
			int unsigned period;
			int unsigned nxt;
			period = (period_reg == 0) ? 1 : period_reg;
			nxt = phase + 1;
			phase = (nxt >= period) ? 16'd0 : nxt[15:0];
		endfunction

		function logic [4:0] age_out();
			int unsigned count;
			bit [31:0] age;
			count = 0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				if (slot_used[i]) begin
					age = seconds - slot_birth[i];
					if (age > age_limit) begin
						slot_used[i] = 1'b0;
						count++;
					end
				end
			end
			return (count > 31) ? 5'd31 : count[4:0];
		endfunction

		function void note_item(logic [1:0] k, logic [63:0] host, logic [63:0] msg,
				logic [23:0] size, logic [11:0] flen);
			track_result_t r;
			int hit;
			int free_slot;
			int unsigned len;
			int unsigned sum;
			r = '0;
			r.status = fra_pkg::STAT_NONE;
			case (k)
				fra_pkg::KIND_FRAG: begin
					hit = -1;
					free_slot = -1;
					for (int i = 0; i < NUM_ENTRIES; i++) begin
						if (slot_used[i]) begin
							if (hit < 0 && slot_host[i] == host) hit = i;
						end else if (free_slot < 0) begin
							free_slot = i;
						end
					end
					if (hit >= 0 && slot_msg[hit] != msg) begin
						r.restarted = 1'b1;
						slot_msg[hit] = msg;
						slot_bytes[hit] = '0;
						slot_birth[hit] = seconds;
					end else if (hit < 0 && free_slot >= 0) begin
						hit = free_slot;
						slot_used[hit] = 1'b1;
						slot_host[hit] = host;
						slot_msg[hit] = msg;
						slot_bytes[hit] = '0;
						slot_birth[hit] = seconds;
					end
					if (hit < 0) begin
						r.status = fra_pkg::STAT_DROPPED;
					end else begin
						len = (flen > fra_pkg::MAX_FRAG_BYTES) ? fra_pkg::MAX_FRAG_BYTES : flen;
						sum = slot_bytes[hit] + len;
						slot_bytes[hit] = (sum > fra_pkg::BYTES_MAX) ? fra_pkg::BYTES_MAX
							: sum[23:0];
						if (slot_bytes[hit] == size) begin
							r.status = fra_pkg::STAT_COMPLETE;
							r.host = slot_host[hit];
							r.msg = slot_msg[hit];
							slot_used[hit] = 1'b0;
						end else begin
							r.status = fra_pkg::STAT_INCOMPLETE;
						end
					end
					// prune sees the table after this fragment's update
					if (phase == 0) r.evicted = age_out();
					step_phase();
				end
				fra_pkg::KIND_PKT: step_phase();
				fra_pkg::KIND_TICK: seconds = seconds + 1;
				default: ;
			endcase
			due_results.push_back(r);
		endfunction

		function void compare_field(string label, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, label, want, got);
				errors++;
			end
		endfunction

		function void check_result(track_result_t got);
			track_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: result word with nothing expected, status %0d", $time, got.status);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("restarted", want.restarted, got.restarted);
			compare_field("done_host_id", want.host, got.host);
			compare_field("done_msg_id", want.msg, got.msg);
			compare_field("evicted", want.evicted, got.evicted);
		endfunction

		function int pending();
			return due_results.size();
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [1:0]                    kind = fra_pkg::KIND_FRAG;
	logic [63:0]                   host_id = '0;
	logic [63:0]                   msg_id = '0;
	logic [23:0]                   msg_size = '0;
	logic [11:0]                   frag_len = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [1:0]                    status;
	logic                          restarted;
	logic [63:0]                   done_host_id;
	logic [63:0]                   done_msg_id;
	logic [4:0]                    evicted;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [fra_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]                   cfg_data = '0;

	bit gaps_on = 1'b1;
	int quiet_cycles = 0;
	reassembly_scoreboard sb;

	logic [63:0] pool_host[POOL];
	logic [63:0] pool_msg[POOL];
	logic [23:0] pool_size[POOL];
	logic [23:0] pool_sent[POOL];

	fragment_reassembly_tracker_unit #(
		.ENTRIES(NUM_ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.host_id(host_id),
		.msg_id(msg_id),
		.msg_size(msg_size),
		.frag_len(frag_len),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.restarted(restarted),
		.done_host_id(done_host_id),
		.done_msg_id(done_msg_id),
		.evicted(evicted),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(0, 99) < 7);
	end

	always @(posedge clk) begin
		track_result_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.status = status;
			seen.restarted = restarted;
			seen.host = done_host_id;
			seen.msg = done_msg_id;
			seen.evicted = evicted;
			sb.check_result(seen);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Called just after a falling edge; returns just after one with valid still high.
	task automatic send_item(input logic [1:0] k, input logic [63:0] h, input logic [63:0] m,
			input logic [23:0] s, input logic [11:0] f);
		int gap;
		if (gaps_on && $urandom_range(0, 99) < 7) begin
			in_valid = 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(negedge clk);
		end
		kind = k;
		host_id = h;
		msg_id = m;
		msg_size = s;
		frag_len = f;
		in_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
			@(negedge clk);
		end
		sb.note_item(k, h, m, s, f);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [fra_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
			@(negedge clk);
		end
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic configure(input logic [15:0] age, input logic [15:0] period);
		in_valid = 1'b0;
		wait_drained();
		write_reg(fra_pkg::CFG_MAX_AGE, age);
		write_reg(fra_pkg::CFG_PRUNE_INT, period);
		cfg_valid = 1'b0;
	endtask

	task automatic new_message(input int idx);
		pool_msg[idx] = {$urandom, $urandom};
		pool_size[idx] = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'($urandom_range(1, 6000));
		pool_sent[idx] = '0;
	endtask

	task automatic run_mix(input int count);
		int idx;
		int pick;
		int unsigned remain;
		logic [11:0] flen;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			idx = $urandom_range(0, POOL - 1);
			if (pick < 60 || (pick >= 81 && pick < 88)) begin
				// abandon the current message to force a restart
				if (pick >= 81) new_message(idx);
				remain = pool_size[idx] - pool_sent[idx];
				if (remain == 0) flen = '0;
				else if (remain <= 2048 && $urandom_range(0, 1)) flen = remain[11:0];
				else flen = 12'($urandom_range(1, (remain > 2048) ? 2048 : remain));
				send_item(fra_pkg::KIND_FRAG, pool_host[idx], pool_msg[idx], pool_size[idx],
					flen);
				pool_sent[idx] = pool_sent[idx] + flen;
				if (pool_sent[idx] >= pool_size[idx]) new_message(idx);
			end else if (pick < 72) begin
				send_item(fra_pkg::KIND_TICK, {$urandom, $urandom}, {$urandom, $urandom},
					24'($urandom), 12'($urandom));
			end else if (pick < 78) begin
				send_item(fra_pkg::KIND_PKT, {$urandom, $urandom}, {$urandom, $urandom},
					24'($urandom), 12'($urandom));
			end else if (pick < 81) begin
				send_item(KIND_NOP, {$urandom, $urandom}, {$urandom, $urandom}, 24'($urandom),
					12'($urandom));
			end else begin
				send_item(fra_pkg::KIND_FRAG,
					$urandom_range(0, 1) ? pool_host[idx] : {$urandom, $urandom},
					{$urandom, $urandom}, 24'($urandom), 12'($urandom_range(0, 4095)));
			end
		end
	endtask

	initial begin
		logic [15:0] ages[5];
		logic [15:0] periods[5];
		sb = new();
		for (int i = 0; i < POOL; i++) begin
			pool_host[i] = {$urandom, $urandom};
			new_message(i);
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// non-fragment kinds with extreme fields
		send_item(fra_pkg::KIND_TICK, '0, '0, '0, '0);
		send_item(KIND_NOP, '1, '1, '1, '1);
		send_item(fra_pkg::KIND_PKT, '0, '0, '0, '0);
		// zero size message completes at once
		send_item(fra_pkg::KIND_FRAG, '0, '0, '0, '0);
		// oversized fragment is clamped
		send_item(fra_pkg::KIND_FRAG, '1, '1, fra_pkg::BYTES_MAX, 12'hFFF);
		// new message id restarts, then completes in one fragment
		send_item(fra_pkg::KIND_FRAG, '1, 64'd5, 24'd2048, 12'd2048);
		send_item(fra_pkg::KIND_FRAG, 64'h1234, 64'd1, 24'd3000, 12'd2048);
		send_item(fra_pkg::KIND_FRAG, 64'h1234, 64'd1, 24'd3000, 12'd952);
		// fill the table, then one more host is dropped
		for (int i = 0; i < NUM_ENTRIES; i++)
			send_item(fra_pkg::KIND_FRAG, 64'd100 + i, 64'd7, 24'd5000, 12'd100);
		send_item(fra_pkg::KIND_FRAG, 64'h77, 64'd7, 24'd5000, 12'd100);
		// age out everything on the second fragment below, once the prune phase has wrapped
		configure(16'd0, 16'd1);
		write_reg(CFG_UNUSED, 16'hFFFF);
		cfg_valid = 1'b0;
		send_item(fra_pkg::KIND_TICK, '0, '0, '0, '0);
		send_item(fra_pkg::KIND_FRAG, 64'h77, 64'd7, 24'd5000, 12'd100);
		send_item(fra_pkg::KIND_FRAG, 64'h78, 64'd7, 24'd5000, 12'd100);

		ages = '{fra_pkg::MAX_AGE_RESET, 16'd3, 16'd0, 16'hFFFF,
			16'($urandom_range(0, 20))};
		periods = '{fra_pkg::PRUNE_INT_RESET, 16'd7, 16'd0, 16'd1,
			16'($urandom_range(1, 30))};
		for (int p = 0; p < 5; p++) begin
			configure(ages[p], periods[p]);
			gaps_on = (p != 2);
			run_mix(80);
			// hold off until every result is back
			in_valid = 1'b0;
			wait_drained();
			run_mix(80);
		end
		gaps_on = 1'b1;

		in_valid = 1'b0;
		wait_drained();
		repeat (2 * NUM_ENTRIES + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
